### rtl/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

  // Frame position bookkeeping
  localparam int unsigned POS_W          = 7;
  localparam int unsigned WRAP_LIMIT     = 100;
  localparam int unsigned PAYLOAD_DEPTH  = 6;
  localparam int unsigned PAYLOAD_FIRST  = 2;

  // Framing bytes
  localparam logic [7:0] HDR_FIRST   = 8'hFA;
  localparam logic [7:0] HDR_SECOND  = 8'hAF;
  localparam logic [7:0] TAIL_FIRST  = 8'hFB;
  localparam logic [7:0] TAIL_SECOND = 8'hBF;

  // Command codes
  localparam logic [7:0] CMD_SERVO  = 8'h06;
  localparam logic [7:0] CMD_MAGNET = 8'h09;
  localparam logic [7:0] CMD_DVL    = 8'h04;

  // Selector values
  localparam logic [7:0] SEL_ZERO = 8'h00;
  localparam logic [7:0] SEL_ONE  = 8'h01;

  localparam logic [31:0] SERVO_A_RESET = 32'h3F00_0000;
  localparam logic [31:0] SERVO_B_RESET = 32'h0000_0000;

  typedef enum logic [1:0] {
    DVL_NONE  = 2'd0,
    DVL_START = 2'd1,
    DVL_STOP  = 2'd2
  } dvl_req_e;

  typedef struct packed {
    logic [POS_W-1:0]                  pos;
    logic [7:0]                        prev;
    logic [PAYLOAD_DEPTH-1:0][7:0]     payload;
    logic [31:0]                       servo_a;
    logic [31:0]                       servo_b;
    logic                              magnet;
  } parser_state_t;

  typedef struct packed {
    dvl_req_e dvl;
    logic     frame_end;
  } frame_event_t;

endpackage

`default_nettype wire

### rtl/cfp_step.sv
`default_nettype none

module cfp_step import cfp_pkg::*; (
  input  wire parser_state_t state_i,
  input  wire logic [7:0]    byte_i,
  output parser_state_t      state_o,
  output frame_event_t       event_o
);

  logic                          hdr_hit;
  logic                          tail_hit;
  logic [POS_W-1:0]              pos_mid;
  logic [PAYLOAD_DEPTH-1:0][7:0] payload;
  logic [7:0]                    cmd;
  logic [7:0]                    sel;
  logic [31:0]                   word;

  // Store the byte at its payload slot first; a tail decodes the updated store.
  always_comb begin
    payload = state_i.payload;
    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
      if (state_i.pos == POS_W'(i + PAYLOAD_FIRST)) begin
        payload[i] = byte_i;
      end
    end
  end

  assign cmd  = payload[0];
  assign sel  = payload[1];
  assign word = {payload[5], payload[4], payload[3], payload[2]};

  assign hdr_hit  = (state_i.pos > POS_W'(1)) && (state_i.prev == HDR_FIRST) &&
                    (byte_i == HDR_SECOND);
  assign tail_hit = !hdr_hit && (state_i.pos != '0) && (state_i.prev == TAIL_FIRST) &&
                    (byte_i == TAIL_SECOND);
  assign pos_mid  = hdr_hit ? POS_W'(1) : state_i.pos;

  always_comb begin
    state_o         = state_i;
    state_o.payload = payload;
    state_o.prev    = byte_i;
    event_o.dvl       = DVL_NONE;
    event_o.frame_end = tail_hit;

    if (tail_hit || (pos_mid > POS_W'(WRAP_LIMIT))) begin
      state_o.pos = '0;
    end else begin
      state_o.pos = pos_mid + POS_W'(1);
    end

    if (tail_hit) begin
      unique case (cmd)
        CMD_SERVO: begin
          if (sel == SEL_ZERO) state_o.servo_a = word;
          if (sel == SEL_ONE)  state_o.servo_b = word;
        end
        CMD_MAGNET: begin
          state_o.magnet = (sel != SEL_ZERO);
        end
        CMD_DVL: begin
          if (sel == SEL_ONE)  event_o.dvl = DVL_START;
          if (sel == SEL_ZERO) event_o.dvl = DVL_STOP;
        end
        default: begin
          // unknown command: settings hold
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/command_frame_parser.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ------------------------------------------
// in        input      in_valid_i/in_ready_o  rx_byte_i[7:0]
// out       output     out_valid_o/out_ready_i servo_a_bits_o, servo_b_bits_o, magnet_on_o,
//                                             dvl_request_o[1:0], frame_end_o
//
// One result transaction per input transaction. An accepted byte is loaded into the input
// register and moves through the frame decode into the result register once that register
// is free or draining. A new byte is accepted every cycle while the output is not stalled.
// Reset loads the frame position, previous byte and payload store with zero,
// servo 0 with 0x3F000000 (0.5) and servo 1 and the magnet with zero.
// A stall on the output holds the result register; the input register still takes
// one more byte, and further input is held off until the result is taken.

module command_frame_parser import cfp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      servo_a_bits_o,
  output logic [31:0]      servo_b_bits_o,
  output logic             magnet_on_o,
  output logic [1:0]       dvl_request_o,
  output logic             frame_end_o
);

  // Input register stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Parser state
  parser_state_t state_q;
  parser_state_t state_d;
  frame_event_t  step_evt;

  // Result register
  logic         out_valid_q;
  logic [31:0]  res_servo_a_q;
  logic [31:0]  res_servo_b_q;
  logic         res_magnet_q;
  frame_event_t res_evt_q;

  logic advance;

  // Move the held byte into decode when the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  cfp_step u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .state_o (state_d),
    .event_o (step_evt)
  );

  // Input register: hold the byte until decode takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Parser state advances only when a byte is decoded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.pos     <= '0;
      state_q.prev    <= '0;
      state_q.payload <= '0;
      state_q.servo_a <= SERVO_A_RESET;
      state_q.servo_b <= SERVO_B_RESET;
      state_q.magnet  <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: load on decode, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_servo_a_q <= state_d.servo_a;
      res_servo_b_q <= state_d.servo_b;
      res_magnet_q  <= state_d.magnet;
      res_evt_q     <= step_evt;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign servo_a_bits_o = res_servo_a_q;
  assign servo_b_bits_o = res_servo_b_q;
  assign magnet_on_o    = res_magnet_q;
  assign dvl_request_o  = 2'(res_evt_q.dvl);
  assign frame_end_o    = res_evt_q.frame_end;

  // A DVL request only ever comes with a completed tail.
  a_dvl_needs_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (dvl_request_o != 2'(DVL_NONE))) |-> frame_end_o)
    else $error("dvl request without frame tail");

  // The frame position never runs past one beyond the wrap limit.
  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos <= POS_W'(WRAP_LIMIT + 1))
    else $error("frame position out of range");

  // A decoded tail returns the position to zero.
  a_tail_resets_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step_evt.frame_end) |=> (state_q.pos == '0))
    else $error("position not cleared after tail");

  // A byte blocked in the input register stays put.
  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("input stage lost a held byte");

endmodule

`default_nettype wire

### tb/sv/tb_command_frame_parser.sv
`timescale 1ns / 1ps

module tb_command_frame_parser;
  import cfp_pkg::*;

  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned STIM_BYTES    = 2000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // One result transaction: the settings after a byte plus the per-byte events.
  typedef struct packed {
    logic [31:0] servo_a;
    logic [31:0] servo_b;
    logic        magnet;
    dvl_req_e    dvl;
    logic        frame_end;
  } status_t;

  // Frame decoder mirror plus the queue of status words still owed by the block.
  class frame_scoreboard;
    localparam int unsigned REPORT_LIMIT = 10;

    status_t          expected_status_q[$];
    logic [POS_W-1:0] pos;
    logic [7:0]       prev;
    logic [7:0]       payload [PAYLOAD_DEPTH];
    logic [31:0]      servo_a;
    logic [31:0]      servo_b;
    logic             magnet;
    int unsigned      failures;

    function new();
      pos      = '0;
      prev     = '0;
      foreach (payload[i]) payload[i] = '0;
      servo_a  = SERVO_A_RESET;
      servo_b  = SERVO_B_RESET;
      magnet   = 1'b0;
      failures = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Advance the decoder by one accepted byte and queue the status it must produce.
    function void take_byte(logic [7:0] rx);
      int unsigned p;
      logic [7:0]  cmd;
      logic [7:0]  sel;
      status_t     st;
      p            = pos;
      st.dvl       = DVL_NONE;
      st.frame_end = 1'b0;
      // Store first, so a tail decodes the byte that just landed too
      if (p >= PAYLOAD_FIRST && p < PAYLOAD_FIRST + PAYLOAD_DEPTH)
        payload[p - PAYLOAD_FIRST] = rx;
      if (p > 1 && prev == HDR_FIRST && rx == HDR_SECOND) begin
        p = 1;
      end else if (p > 0 && prev == TAIL_FIRST && rx == TAIL_SECOND) begin
        cmd          = payload[0];
        sel          = payload[1];
        st.frame_end = 1'b1;
        case (cmd)
          CMD_SERVO: begin
            if (sel == SEL_ZERO)
              servo_a = {payload[5], payload[4], payload[3], payload[2]};
            else if (sel == SEL_ONE)
              servo_b = {payload[5], payload[4], payload[3], payload[2]};
          end
          CMD_MAGNET: magnet = (sel != SEL_ZERO);
          CMD_DVL: begin
            if (sel == SEL_ONE)
              st.dvl = DVL_START;
            else if (sel == SEL_ZERO)
              st.dvl = DVL_STOP;
          end
          default: ;
        endcase
      end
      if (st.frame_end || p > WRAP_LIMIT)
        p = 0;
      else
        p = p + 1;
      pos        = p[POS_W-1:0];
      prev       = rx;
      st.servo_a = servo_a;
      st.servo_b = servo_b;
      st.magnet  = magnet;
      expected_status_q.push_back(st);
    endfunction

    function void match_status(status_t got);
      status_t want;
      if (expected_status_q.size() == 0) begin
        flag($sformatf("unexpected result: servo_a %h servo_b %h magnet %b dvl %0d end %b",
                       got.servo_a, got.servo_b, got.magnet, got.dvl, got.frame_end));
        return;
      end
      want = expected_status_q.pop_front();
      if (got.servo_a !== want.servo_a || got.servo_b !== want.servo_b ||
          got.magnet !== want.magnet || got.dvl !== want.dvl ||
          got.frame_end !== want.frame_end)
        flag($sformatf({"mismatch (expected/actual): servo_a %h/%h servo_b %h/%h ",
                        "magnet %b/%b dvl %0d/%0d end %b/%b"},
                       want.servo_a, got.servo_a, want.servo_b, got.servo_b,
                       want.magnet, got.magnet, want.dvl, got.dvl,
                       want.frame_end, got.frame_end));
    endfunction

    function int unsigned pending();
      return expected_status_q.size();
    endfunction
  endclass

  // Drive every input to a known value from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] servo_a_bits_o;
  logic [31:0] servo_b_bits_o;
  logic        magnet_on_o;
  logic [1:0]  dvl_request_o;
  logic        frame_end_o;

  frame_scoreboard sb = new();

  int unsigned sent_bytes   = 0;
  int unsigned burst_left   = 0;
  bit          hold_off_req = 1'b0;

  command_frame_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .servo_a_bits_o (servo_a_bits_o),
    .servo_b_bits_o (servo_b_bits_o),
    .magnet_on_o    (magnet_on_o),
    .dvl_request_o  (dvl_request_o),
    .frame_end_o    (frame_end_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Byte pickers: lean on the extremes for payload, on framing bytes for noise.
  function automatic logic [7:0] pick_body_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_noise_byte();
    case ($urandom_range(0, 7))
      0:       return HDR_FIRST;
      1:       return HDR_SECOND;
      2:       return TAIL_FIRST;
      3:       return TAIL_SECOND;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Filler never opens a pair, so a run of it walks the position straight up.
  function automatic logic [7:0] pick_filler_byte();
    logic [7:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (b == HDR_FIRST || b == TAIL_FIRST);
    return b;
  endfunction

  // Offer one byte and hold it until the block takes it. Bursts of random length
  // are separated by random gaps; about a quarter of the bursts run on without one.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_byte(b);
    burst_left--;
    sent_bytes++;
  endtask

  // Drop valid and wait until the block has returned every status it owes.
  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Build one random frame and send it. Most are well formed with random content;
  // the rest are noise, broken frames and runaway frames that hit the wrap limit.
  task automatic send_random_frame();
    logic [7:0]  frame_q[$];
    logic [7:0]  cmd;
    logic [7:0]  sel;
    int unsigned kind;
    int unsigned nbody;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // Skip the header now and then: right after a tail the position is already 0
      if ($urandom_range(0, 7) != 0) begin
        frame_q.push_back(HDR_FIRST);
        frame_q.push_back(HDR_SECOND);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd = CMD_SERVO;
        4, 5:       cmd = CMD_MAGNET;
        6, 7:       cmd = CMD_DVL;
        default:    cmd = pick_body_byte();
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: sel = SEL_ZERO;
        4, 5, 6:    sel = SEL_ONE;
        default:    sel = pick_body_byte();
      endcase
      nbody = (cmd == CMD_SERVO) ? 4 : $urandom_range(0, 4);
      // Short or overlong body: the tail then decodes stale payload or ignores the extra byte
      if ($urandom_range(0, 9) == 0) nbody = $urandom_range(0, 5);
      frame_q.push_back(cmd);
      frame_q.push_back(sel);
      repeat (nbody) frame_q.push_back(pick_body_byte());
      frame_q.push_back(TAIL_FIRST);
      frame_q.push_back(TAIL_SECOND);
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 8)) frame_q.push_back(pick_noise_byte());
    end else if (kind < 98) begin
      frame_q.push_back(HDR_FIRST);
      frame_q.push_back(HDR_SECOND);
      repeat ($urandom_range(0, 6)) frame_q.push_back(pick_body_byte());
      case ($urandom_range(0, 2))
        0: ;
        1: begin
          // Half a tail followed by something else
          frame_q.push_back(TAIL_FIRST);
          frame_q.push_back(pick_body_byte());
        end
        default: begin
          // Restart the frame in the middle
          frame_q.push_back(HDR_FIRST);
          frame_q.push_back(HDR_SECOND);
        end
      endcase
    end else begin
      // Close any open frame so the filler starts at position 0, then walk past
      // the wrap limit. The pair that follows splits across the wrap, so its
      // second byte lands at position 0 and must not be recognized.
      frame_q.push_back(TAIL_FIRST);
      frame_q.push_back(TAIL_SECOND);
      repeat (WRAP_LIMIT + 1) frame_q.push_back(pick_filler_byte());
      if ($urandom_range(0, 1) == 0) begin
        frame_q.push_back(HDR_FIRST);
        frame_q.push_back(HDR_SECOND);
      end else begin
        frame_q.push_back(TAIL_FIRST);
        frame_q.push_back(TAIL_SECOND);
      end
    end
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  initial begin : stimulus
    logic [7:0] directed_q[$];
    bit         held;
    bit         drained;
    held    = 1'b0;
    drained = 1'b0;
    directed_q = '{
      // Header pair at positions 0 and 1 (too early to match), then servo 1 loaded with all ones
      HDR_FIRST, HDR_SECOND, CMD_SERVO, SEL_ONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      TAIL_FIRST, TAIL_SECOND,
      // Short servo 0 frame: the upper word bytes are left over from above
      HDR_FIRST, HDR_SECOND, CMD_SERVO, SEL_ZERO, TAIL_FIRST, TAIL_SECOND,
      // No header: right after a tail the body still starts at position 2
      8'h00, 8'h00, CMD_MAGNET, SEL_ONE, TAIL_FIRST, TAIL_SECOND,
      HDR_FIRST, HDR_SECOND, CMD_DVL, SEL_ONE, TAIL_FIRST, TAIL_SECOND
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_q[i]) send_byte(directed_q[i]);
    pause_until_drained();

    while (sent_bytes < STIM_BYTES) begin
      send_random_frame();
      // Halfway through: stall the receiver for a long stretch while bytes keep coming
      if (!held && sent_bytes > STIM_BYTES / 2) begin
        held         = 1'b1;
        hold_off_req = 1'b1;
      end
      // Later: hold the sender until the block has caught up completely
      if (!drained && sent_bytes > (STIM_BYTES * 3) / 4) begin
        drained = 1'b1;
        pause_until_drained();
      end
    end

    pause_until_drained();
    // Keep watching the output to catch any stray result
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_command_frame_parser OK");
    end else begin
      $display("tb_command_frame_parser NOT OK");
    end
    $finish;
  end

  // Receiver: pick a stall pattern for a random span, then pick again.
  // A hold-off request overrides the pattern, holding ready low, and then clears itself.
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      for (int i = 0; i < span; i++) begin
        @(negedge clk_i);
        if (hold_off_req) begin
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk_i);
          hold_off_req = 1'b0;
        end else begin
          case (mode)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= 1'($urandom_range(0, 1));
            2:       out_ready_i <= ($urandom_range(0, 3) == 0);
            default: out_ready_i <= ((i % 5) < 3);
          endcase
        end
      end
    end
  end

  // Check each result transaction against the oldest expected status
  always @(posedge clk_i) begin : result_monitor
    status_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.servo_a   = servo_a_bits_o;
      got.servo_b   = servo_b_bits_o;
      got.magnet    = magnet_on_o;
      got.dvl       = dvl_req_e'(dvl_request_o);
      got.frame_end = frame_end_o;
      sb.match_status(got);
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_command_frame_parser NOT OK");
        $finish;
      end
    end
  end

endmodule

### command_frame_parser.f
rtl/cfp_pkg.sv
rtl/cfp_step.sv
rtl/command_frame_parser.sv
tb/sv/tb_command_frame_parser.sv
